@@ hw/rtl/fpll_pkg.sv @@
// Shared types and constants for the four-pole ladder lowpass.
// Holds controller state, datapath commands, register indexes and fixed-point widths.
package fpll_pkg;

    localparam int STAGE_COUNT_DEF = 4;
    localparam int SMP_W           = 16;
    localparam int STG_W           = 24;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DAT_W       = 16;
    localparam int DIV_STEPS       = 25;
    localparam int CNT_W           = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DRV, ST_FB, ST_A, ST_SQ, ST_S, ST_NUM, ST_DIVI,
        ST_DIV, ST_SAT, ST_SMUL, ST_SUPD, ST_MMUL, ST_MADD, ST_LMUL, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DRV, OP_FB, OP_A, OP_SQ, OP_S, OP_NUM, OP_DIVI,
        OP_DIV, OP_SAT, OP_SMUL, OP_SUPD, OP_MMUL, OP_MADD, OP_LMUL, OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic stage_last;
    } t_sts;

endpackage

@@ hw/rtl/fpll_ctrl.sv @@
// Sequencing state machine of the ladder lowpass.
// Issues fpll_pkg::t_cmd to the datapath and owns the handshakes and divider count.
module fpll_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output fpll_pkg::t_cmd o_cmd,
    input  fpll_pkg::t_sts i_sts
);

    fpll_pkg::t_state r_state, n_state;
    logic [fpll_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpll_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd.op    = fpll_pkg::OP_NONE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            fpll_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = fpll_pkg::OP_LOAD;
                    n_state  = fpll_pkg::ST_DRV;
                end
            end
            fpll_pkg::ST_DRV: begin
                o_cmd.op = fpll_pkg::OP_DRV;
                n_state  = fpll_pkg::ST_FB;
            end
            fpll_pkg::ST_FB: begin
                o_cmd.op = fpll_pkg::OP_FB;
                n_state  = fpll_pkg::ST_A;
            end
            fpll_pkg::ST_A: begin
                o_cmd.op = fpll_pkg::OP_A;
                n_state  = fpll_pkg::ST_SQ;
            end
            fpll_pkg::ST_SQ: begin
                o_cmd.op = fpll_pkg::OP_SQ;
                n_state  = fpll_pkg::ST_S;
            end
            fpll_pkg::ST_S: begin
                o_cmd.op = fpll_pkg::OP_S;
                n_state  = fpll_pkg::ST_NUM;
            end
            fpll_pkg::ST_NUM: begin
                o_cmd.op = fpll_pkg::OP_NUM;
                n_state  = fpll_pkg::ST_DIVI;
            end
            fpll_pkg::ST_DIVI: begin
                o_cmd.op = fpll_pkg::OP_DIVI;
                n_cnt    = '0;
                n_state  = fpll_pkg::ST_DIV;
            end
            fpll_pkg::ST_DIV: begin
                o_cmd.op = fpll_pkg::OP_DIV;
                if (r_cnt == fpll_pkg::CNT_W'(fpll_pkg::DIV_STEPS - 1)) begin
                    n_state = fpll_pkg::ST_SAT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            fpll_pkg::ST_SAT: begin
                o_cmd.op = fpll_pkg::OP_SAT;
                n_state  = fpll_pkg::ST_SMUL;
            end
            fpll_pkg::ST_SMUL: begin
                o_cmd.op = fpll_pkg::OP_SMUL;
                n_state  = fpll_pkg::ST_SUPD;
            end
            fpll_pkg::ST_SUPD: begin
                o_cmd.op = fpll_pkg::OP_SUPD;
                n_state  = i_sts.stage_last ? fpll_pkg::ST_MMUL : fpll_pkg::ST_SMUL;
            end
            fpll_pkg::ST_MMUL: begin
                o_cmd.op = fpll_pkg::OP_MMUL;
                n_state  = fpll_pkg::ST_MADD;
            end
            fpll_pkg::ST_MADD: begin
                o_cmd.op = fpll_pkg::OP_MADD;
                n_state  = fpll_pkg::ST_LMUL;
            end
            fpll_pkg::ST_LMUL: begin
                o_cmd.op = fpll_pkg::OP_LMUL;
                n_state  = fpll_pkg::ST_OUT;
            end
            fpll_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = fpll_pkg::OP_OUT;
                    n_out_valid = 1'b1;
                    n_state     = fpll_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpll_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ hw/rtl/fpll_dp.sv @@
// Datapath of the ladder lowpass: config registers, shared multiplier, divider, stages.
// Driven by fpll_pkg::t_cmd from fpll_ctrl.
module fpll_dp #(
    parameter int STAGE_COUNT = fpll_pkg::STAGE_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  fpll_pkg::t_cmd                  i_cmd,
    output fpll_pkg::t_sts                  o_sts,
    input  logic                            i_cfg_we,
    input  logic [fpll_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fpll_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic signed [fpll_pkg::SMP_W-1:0] i_sample_in,
    output logic signed [fpll_pkg::SMP_W-1:0] o_sample_out
);

    localparam int IW = (STAGE_COUNT > 1) ? $clog2(STAGE_COUNT) : 1;
    localparam logic signed [25:0] A_MAX = 26'sd25165824;
    localparam logic signed [25:0] A_MIN = -26'sd25165824;
    localparam logic [28:0] K27 = 29'd226492416;
    localparam logic signed [23:0] S_MAX = 24'sd8388607;
    localparam logic signed [23:0] S_MIN = -24'sd8388608;

    logic [15:0] r_coef, r_res, r_drive, r_mix, r_level;
    logic [1:0]  r_tap;

    logic signed [15:0] r_x;
    logic signed [57:0] r_prod;
    logic signed [28:0] r_t1;
    logic signed [25:0] r_a;
    logic [26:0] r_s;
    logic [29:0] r_den;
    logic [29:0] r_rem;
    logic [24:0] r_q;
    logic        r_neg;
    logic signed [23:0] r_prev;
    logic signed [23:0] r_wet;
    logic signed [26:0] r_mixed;
    logic signed [15:0] r_out;
    logic [IW-1:0] r_idx;
    logic signed [23:0] r_stage [STAGE_COUNT];

    logic signed [27:0] mul_a;
    logic signed [29:0] mul_b;
    logic [18:0] res7;
    logic [15:0] mix_eff;
    logic signed [23:0] x23;
    logic [IW-1:0] tap_eff;
    logic stage_last;

    logic signed [29:0] a_full;
    logic signed [57:0] mag;
    logic [30:0] trial;
    logic trial_ge;
    logic signed [25:0] uq;
    logic signed [24:0] diff;
    logic signed [26:0] nv;
    logic signed [23:0] nv_sat;
    logic signed [22:0] y_full;

    assign res7    = {r_res, 3'b000} - {3'b000, r_res};
    assign mix_eff = (r_mix > 16'd32768) ? 16'd32768 : r_mix;
    assign x23     = {r_x, 8'h00};
    assign tap_eff = (int'(r_tap) >= STAGE_COUNT) ? IW'(STAGE_COUNT - 1) : IW'(r_tap);
    assign stage_last = (r_idx == IW'(STAGE_COUNT - 1));
    assign o_sts.stage_last = stage_last;
    assign diff = 25'(r_prev) - 25'(r_stage[r_idx]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            fpll_pkg::OP_DRV: begin
                mul_a = 28'(r_x);
                mul_b = $signed({14'd0, r_drive});
            end
            fpll_pkg::OP_FB: begin
                mul_a = 28'(r_stage[STAGE_COUNT-1]);
                mul_b = $signed({11'd0, res7});
            end
            fpll_pkg::OP_SQ: begin
                mul_a = 28'(r_a);
                mul_b = 30'(r_a);
            end
            fpll_pkg::OP_NUM: begin
                mul_a = 28'(r_a);
                mul_b = $signed({1'b0, K27 + {2'b00, r_s}});
            end
            fpll_pkg::OP_SMUL: begin
                mul_a = 28'(diff);
                mul_b = $signed({14'd0, r_coef});
            end
            fpll_pkg::OP_MMUL: begin
                mul_a = 28'(25'(r_wet) - 25'(x23));
                mul_b = $signed({14'd0, mix_eff});
            end
            fpll_pkg::OP_LMUL: begin
                mul_a = 28'(r_mixed);
                mul_b = $signed({14'd0, r_level});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign a_full   = 30'(r_t1) - 30'($signed(r_prod[43:17]));
    assign mag      = r_prod[57] ? -r_prod : r_prod;
    assign trial    = {r_rem, r_q[24]};
    assign trial_ge = (trial >= {1'b0, r_den});
    assign uq       = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
    assign nv       = 27'(r_stage[r_idx]) + 27'($signed(r_prod[41:16]));
    assign nv_sat   = (nv > 27'(S_MAX)) ? S_MAX : ((nv < 27'(S_MIN)) ? S_MIN : nv[23:0]);
    assign y_full   = $signed(r_prod[42:20]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= 16'd6554;
            r_res   <= 16'd0;
            r_drive <= 16'd4096;
            r_tap   <= 2'd3;
            r_mix   <= 16'd32768;
            r_level <= 16'd4096;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fpll_pkg::CFG_COEF:  r_coef  <= i_cfg_data;
                fpll_pkg::CFG_RES:   r_res   <= i_cfg_data;
                fpll_pkg::CFG_DRIVE: r_drive <= i_cfg_data;
                fpll_pkg::CFG_TAP:   r_tap   <= i_cfg_data[1:0];
                fpll_pkg::CFG_MIX:   r_mix   <= i_cfg_data;
                fpll_pkg::CFG_LEVEL: r_level <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int i = 0; i < STAGE_COUNT; i++) begin
                r_stage[i] <= '0;
            end
        end else begin
            if (i_cmd.op == fpll_pkg::OP_SAT) begin
                r_idx <= '0;
            end
            if (i_cmd.op == fpll_pkg::OP_SUPD) begin
                r_stage[r_idx] <= nv_sat;
                if (!stage_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == fpll_pkg::OP_DRV || i_cmd.op == fpll_pkg::OP_FB ||
            i_cmd.op == fpll_pkg::OP_SQ || i_cmd.op == fpll_pkg::OP_NUM ||
            i_cmd.op == fpll_pkg::OP_SMUL || i_cmd.op == fpll_pkg::OP_MMUL ||
            i_cmd.op == fpll_pkg::OP_LMUL) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_cmd.op)
            fpll_pkg::OP_LOAD: r_x <= i_sample_in;
            fpll_pkg::OP_FB:   r_t1 <= $signed(r_prod[32:4]);
            fpll_pkg::OP_A: begin
                if (a_full > 30'(A_MAX)) begin
                    r_a <= A_MAX;
                end else if (a_full < 30'(A_MIN)) begin
                    r_a <= A_MIN;
                end else begin
                    r_a <= a_full[25:0];
                end
            end
            fpll_pkg::OP_S:    r_s <= r_prod[49:23];
            fpll_pkg::OP_NUM:  r_den <= 30'(K27) + {r_s, 3'b000} + {3'b000, r_s};
            fpll_pkg::OP_DIVI: begin
                r_rem <= mag[54:25];
                r_q   <= mag[24:0];
                r_neg <= r_prod[57];
            end
            fpll_pkg::OP_DIV: begin
                r_rem <= trial_ge ? 30'(trial - {1'b0, r_den}) : trial[29:0];
                r_q   <= {r_q[23:0], trial_ge};
            end
            fpll_pkg::OP_SAT: begin
                if (uq > 26'(S_MAX)) begin
                    r_prev <= S_MAX;
                end else if (uq < 26'(S_MIN)) begin
                    r_prev <= S_MIN;
                end else begin
                    r_prev <= uq[23:0];
                end
            end
            fpll_pkg::OP_SUPD: begin
                r_prev <= nv_sat;
                if (r_idx == tap_eff) begin
                    r_wet <= nv_sat;
                end
            end
            fpll_pkg::OP_MADD: r_mixed <= 27'(x23) + 27'($signed(r_prod[40:15]));
            fpll_pkg::OP_OUT: begin
                if (y_full > 23'sd32767) begin
                    r_out <= 16'sh7fff;
                end else if (y_full < -23'sd32768) begin
                    r_out <= -16'sd32768;
                end else begin
                    r_out <= y_full[15:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sample_out = r_out;

endmodule

@@ hw/rtl/four_pole_ladder_lowpass.sv @@
// Top level of the four-pole ladder lowpass with saturated resonance feedback.
// Uses fpll_pkg, fpll_ctrl and fpll_dp.
//
// One sample at a time: each item passes through the 25-step restoring divider of the tanh
// curve and the shared multiplier, used once per stage. The result waits in an output
// register, and the next item is taken while it waits.
// Configuration writes are taken at any cycle and should be made while the block is idle;
// writes to indexes above five are dropped.
module four_pole_ladder_lowpass #(
    parameter int STAGE_COUNT = fpll_pkg::STAGE_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [fpll_pkg::SMP_W-1:0]  i_sample_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [fpll_pkg::SMP_W-1:0]  o_sample_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fpll_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [fpll_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    fpll_pkg::t_cmd cmd;
    fpll_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fpll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    fpll_dp #(
        .STAGE_COUNT (STAGE_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .o_sample_out (o_sample_out)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("item accepted while a sample is in work");

    a_idle_on_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("result posted while the sequencer is busy");

    a_load_only_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == fpll_pkg::OP_LOAD) |-> (o_ready && i_valid))
        else $error("sample latched without a handshake");

endmodule

@@ dv/tb_four_pole_ladder_lowpass.sv @@
// Self-checking testbench for four_pole_ladder_lowpass: drives samples and register writes,
// predicts every output sample with a fixed-point ladder model and compares in order.
// Depends on fpll_pkg and the four_pole_ladder_lowpass RTL.
`timescale 1ns / 1ps

module tb_four_pole_ladder_lowpass;

    localparam int NSTG = fpll_pkg::STAGE_COUNT_DEF;
    localparam longint ONE23 = 64'sd1 << 23;
    localparam logic [fpll_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [fpll_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic signed [fpll_pkg::SMP_W-1:0] i_sample_in = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [fpll_pkg::SMP_W-1:0] o_sample_out;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [fpll_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [fpll_pkg::CFG_DAT_W-1:0] i_cfg_data = '0;

    four_pole_ladder_lowpass dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint ladder[NSTG];
    longint coef_q, res_q, drive_q, tap_q, mix_q, level_q;
    logic signed [fpll_pkg::SMP_W-1:0] expected_samples[$];
    int errors = 0;

    typedef struct {
        logic [15:0] smp;
        bit          known;
        logic [15:0] want;
    } t_row;

    function automatic longint fshr(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [15:0] filter_sample(logic signed [15:0] smp);
        longint x, a, s, mag, num, den, u, prev, wet, x23, mixed, y, mx;
        int t;
        x = smp;
        a = fshr(drive_q * x, 4) - fshr(res_q * 7 * ladder[NSTG-1], 17);
        a = clip(a, -3 * ONE23, 3 * ONE23);
        mag = a < 0 ? -a : a;
        s = (mag * mag) >> 23;
        num = a * (27 * ONE23 + s);
        den = 27 * ONE23 + 9 * s;
        u = clip(num / den, -ONE23, ONE23 - 1);
        prev = u;
        for (int i = 0; i < NSTG; i++) begin
            ladder[i] = clip(ladder[i] + fshr(coef_q * (prev - ladder[i]), 16),
                             -ONE23, ONE23 - 1);
            prev = ladder[i];
        end
        t = tap_q >= NSTG ? NSTG - 1 : int'(tap_q);
        wet = ladder[t];
        mx = mix_q > 32768 ? 32768 : mix_q;
        x23 = x * 256;
        mixed = x23 + fshr(mx * (wet - x23), 15);
        y = clip(fshr(mixed * level_q, 20), -32768, 32767);
        return y[15:0];
    endfunction

    task automatic reset_model();
        foreach (ladder[i]) ladder[i] = 0;
        coef_q = 6554; res_q = 0; drive_q = 4096; tap_q = 3; mix_q = 32768; level_q = 4096;
    endtask

    // leave valid high; the next sample send drops it
    task automatic write_reg(logic [fpll_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            fpll_pkg::CFG_COEF:  coef_q = val;
            fpll_pkg::CFG_RES:   res_q = val;
            fpll_pkg::CFG_DRIVE: drive_q = val;
            fpll_pkg::CFG_TAP:   tap_q = val[1:0];
            fpll_pkg::CFG_MIX:   mix_q = val;
            fpll_pkg::CFG_LEVEL: level_q = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (expected_samples.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] smp);
        int gap;
        i_cfg_valid <= 1'b0;
        gap = $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_sample_in <= smp;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expected_samples.push_back(filter_sample(smp));
        @(negedge i_clk);
    endtask

    task automatic random_config();
        write_reg(fpll_pkg::CFG_COEF,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20000)));
        write_reg(fpll_pkg::CFG_RES, 16'($urandom));
        write_reg(fpll_pkg::CFG_DRIVE,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384)));
        write_reg(fpll_pkg::CFG_TAP, 16'($urandom));
        write_reg(fpll_pkg::CFG_MIX,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768)));
        write_reg(fpll_pkg::CFG_LEVEL,
                  $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 16384)));
    endtask

    // consumer with random stall
    initial begin
        int stall;
        logic signed [15:0] want;
        forever begin
            @(negedge i_clk);
            stall = $urandom_range(0, 17);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (expected_samples.size() == 0) begin
                $error("sample_out: unexpected item, actual %0d", o_sample_out);
                errors++;
            end else begin
                want = expected_samples.pop_front();
                if (o_sample_out !== want) begin
                    $error("sample_out: expected %0d actual %0d", want, o_sample_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        logic [15:0] d;
        reset_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero in after reset gives zero out; full-scale and one-LSB samples follow
        rows.push_back('{16'h0000, 1, 16'h0000});
        rows.push_back('{16'h7FFF, 0, 0});
        rows.push_back('{16'h8000, 0, 0});
        rows.push_back('{16'h8000, 0, 0});
        rows.push_back('{16'h0001, 0, 0});
        rows.push_back('{16'hFFFF, 0, 0});
        foreach (rows[i]) begin
            send_sample(rows[i].smp);
            if (rows[i].known && expected_samples[$] !== rows[i].want) begin
                $error("sample_out: table expected %0d model %0d", rows[i].want,
                       expected_samples[$]);
                errors++;
            end
        end
        i_valid <= 1'b0;
        drain();

        // coef 0 holds, mix>full, dead idx; coef/res/drive/level max per tap; mix/level 0
        write_reg(fpll_pkg::CFG_COEF, 16'd0);
        write_reg(fpll_pkg::CFG_MIX, 16'hFFFF);
        write_reg(CFG_SPARE_LO, 16'h1234);
        write_reg(CFG_SPARE_HI, 16'hFFFF);
        for (int i = 0; i < 3; i++) send_sample(16'h7FFF);
        i_valid <= 1'b0;
        drain();
        write_reg(fpll_pkg::CFG_COEF, 16'hFFFF);
        write_reg(fpll_pkg::CFG_RES, 16'hFFFF);
        write_reg(fpll_pkg::CFG_DRIVE, 16'hFFFF);
        write_reg(fpll_pkg::CFG_LEVEL, 16'hFFFF);
        for (int t = 0; t < 4; t++) begin
            write_reg(fpll_pkg::CFG_TAP, 16'(t));
            send_sample(16'h7FFF);
            send_sample(16'h8000);
            i_valid <= 1'b0;
            drain();
        end
        write_reg(fpll_pkg::CFG_MIX, 16'd0);
        write_reg(fpll_pkg::CFG_LEVEL, 16'd0);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        i_valid <= 1'b0;
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            for (int n = 0; n < 130; n++) begin
                case ($urandom_range(0, 3))
                    0: d = 16'($urandom);
                    1: d = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    default: d = 16'($signed(16'($urandom_range(0, 8000))) - 16'sd4000);
                endcase
                send_sample(d);
            end
            i_valid <= 1'b0;
            drain();
        end
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fpll_pkg.sv
hw/rtl/fpll_ctrl.sv
hw/rtl/fpll_dp.sv
hw/rtl/four_pole_ladder_lowpass.sv
dv/tb_four_pole_ladder_lowpass.sv
